>>> hdl/epoch_seconds_to_civil_date_core_macros.svh
// Assertion macros shared by the checker of the epoch seconds to civil date core
`ifndef EPOCH_SECONDS_TO_CIVIL_DATE_CORE_MACROS_SVH
`define EPOCH_SECONDS_TO_CIVIL_DATE_CORE_MACROS_SVH

// Check a consequent in the same cycle as its antecedent
`define ESCCD_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("esccd check failed");

// Check a consequent in the cycle after its antecedent
`define ESCCD_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("esccd check failed");

`endif

>>> hdl/esccd_pkg.sv
// Shared types, constants and calendar functions of the civil date core
package esccd_pkg;

    // Divisor choice of the shared divider
    typedef enum logic [1:0] {
        DIV_MS  = 2'd0,
        DIV_DAY = 2'd1,
        DIV_SEC = 2'd2,
        DIV_MIN = 2'd3
    } div_sel_t;

    localparam logic [16:0] MS_PER_SEC   = 17'd1000;
    localparam logic [16:0] SECS_PER_DAY = 17'd86400;
    localparam logic [16:0] SECS_PER_MIN = 17'd60;

    // Reciprocals of the divisors, exact over the dividend ranges used:
    // x / 1000 = (x * RECIP_MS) >> 38 for any 32-bit x,
    // x / 86400 = ((x >> 7) * RECIP_DAY) >> 35 for any 32-bit x,
    // x / 60 = ((x >> 2) * RECIP_MIN) >> 19 for x below 2^17
    localparam logic [28:0] RECIP_MS  = 29'd274877907;
    localparam logic [28:0] RECIP_DAY = 29'd50903317;
    localparam logic [28:0] RECIP_MIN = 29'd34953;

    localparam logic [11:0] EPOCH_YEAR       = 12'd1970;
    // Only century year in range that is not a leap year
    localparam logic [11:0] NON_LEAP_CENTURY = 12'd2100;
    localparam logic [3:0]  LAST_MONTH       = 4'd12;
    localparam logic [3:0]  FEBRUARY         = 4'd2;

    localparam logic [16:0] ZONE_RESET = 17'd19800;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     load_in;
        logic     div_start;
        div_sel_t div_sel;
        logic     take_elapsed;
        logic     take_days;
        logic     take_sec;
        logic     take_min;
        logic     year_step;
        logic     month_step;
        logic     load_out;
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_done;
        logic year_done;
        logic month_done;
    } dp_status_t;

    function automatic logic [16:0] div_divisor(input div_sel_t sel);
        logic [16:0] d;
        unique case (sel)
            DIV_MS:  d = MS_PER_SEC;
            DIV_DAY: d = SECS_PER_DAY;
            DIV_SEC: d = SECS_PER_MIN;
            DIV_MIN: d = SECS_PER_MIN;
            default: d = MS_PER_SEC;
        endcase
        return d;
    endfunction

    // Gregorian leap rule, exact for the years 1970 to 2106
    function automatic logic is_leap(input logic [11:0] year);
        return (year[1:0] == 2'b00) && (year != NON_LEAP_CENTURY);
    endfunction

    function automatic logic [8:0] days_in_year(input logic [11:0] year);
        return is_leap(year) ? 9'd366 : 9'd365;
    endfunction

    function automatic logic [4:0] days_in_month(input logic [3:0] month, input logic leap);
        logic [4:0] n;
        unique case (month)
            4'd1:    n = 5'd31;
            4'd2:    n = leap ? 5'd29 : 5'd28;
            4'd3:    n = 5'd31;
            4'd4:    n = 5'd30;
            4'd5:    n = 5'd31;
            4'd6:    n = 5'd30;
            4'd7:    n = 5'd31;
            4'd8:    n = 5'd31;
            4'd9:    n = 5'd30;
            4'd10:   n = 5'd31;
            4'd11:   n = 5'd30;
            4'd12:   n = 5'd31;
            default: n = 5'd31;
        endcase
        return n;
    endfunction

endpackage

>>> hdl/epoch_seconds_to_civil_date_core.sv
// Top level of the epoch seconds to local civil date converter
//
// One request carries a soft-clock base in UTC seconds, the millisecond tick at which it
// was set and the current tick; the result is the local second, minute, hour, day, month
// and year. Elapsed seconds are the wrapped tick difference divided by 1000, added to the
// base and the signed zone offset modulo 2^32. Requests are handled one at a time, and a
// new request can be accepted in the cycle after the result register is loaded. Loading
// the result register waits while an earlier result in it has not yet been taken. The core
// uses the shared constant divider for the millisecond, day, minute and hour splits (a
// reciprocal multiply for the quotient, then a multiply back for the remainder) and then
// walks the years and months, one year or one month a cycle. The result register lets
// the next request start while a result waits. The zone offset register (reset 19800)
// takes a write in any cycle and should be written only while no request is in flight.
module epoch_seconds_to_civil_date_core (
    input  logic               aclk,
    input  logic               aresetn,
    // Zone offset write channel
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic signed [16:0] cfg_data,      // zone_offset_seconds
    // Request channel
    input  logic               s_tvalid,
    output logic               s_tready,
    input  logic [95:0]        s_tdata,       // base_seconds, set_at_ms, now_ms
    // Result channel
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [39:0]        m_tdata        // second_of_minute, minute_of_hour,
                                              // hour_of_day, day_of_month,
                                              // month_of_year, calendar_year, zero pad
);

    esccd_pkg::ctrl_cmd_t  cmd;
    esccd_pkg::dp_status_t status;

    logic [5:0]  second_of_minute;
    logic [5:0]  minute_of_hour;
    logic [4:0]  hour_of_day;
    logic [4:0]  day_of_month;
    logic [3:0]  month_of_year;
    logic [11:0] calendar_year;

    assign cfg_ready = 1'b1;

    esccd_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .status   (status)
    );

    esccd_dpath u_dpath (
        .aclk                 (aclk),
        .aresetn              (aresetn),
        .cfg_we               (cfg_valid),
        .cfg_data             (cfg_data),
        .in_base_seconds      (s_tdata[31:0]),
        .in_set_at_ms         (s_tdata[63:32]),
        .in_now_ms            (s_tdata[95:64]),
        .cmd                  (cmd),
        .status               (status),
        .out_second_of_minute (second_of_minute),
        .out_minute_of_hour   (minute_of_hour),
        .out_hour_of_day      (hour_of_day),
        .out_day_of_month     (day_of_month),
        .out_month_of_year    (month_of_year),
        .out_calendar_year    (calendar_year)
    );

    // Pack the result fields from the lowest bit up
    assign m_tdata = {2'b00, calendar_year, month_of_year, day_of_month,
                      hour_of_day, minute_of_hour, second_of_minute};

endmodule

>>> hdl/esccd_div.sv
// Constant divider: reciprocal multiply for the quotient, multiply back for the rest
module esccd_div (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  esccd_pkg::div_sel_t  sel,
    input  logic [31:0]          dividend,
    output logic                 done,
    output logic [31:0]          quotient,
    output logic [16:0]          remainder
);

    esccd_pkg::div_sel_t sel_reg, sel_next;
    logic [31:0] x_reg, x_next;
    logic [31:0] q_reg, q_next;
    logic [16:0] r_reg, r_next;
    logic        mul_reg, mul_next;
    logic        sub_reg, sub_next;
    logic        done_reg, done_next;
    logic [31:0] mul_a;
    logic [28:0] mul_b;
    logic [60:0] prod;
    logic [31:0] q_calc;
    logic [31:0] back;
    logic [31:0] r_full;

    // Pick the pre-shifted dividend and the matching reciprocal
    always_comb begin
        unique case (sel_reg)
            esccd_pkg::DIV_MS: begin
                mul_a = x_reg;
                mul_b = esccd_pkg::RECIP_MS;
            end
            esccd_pkg::DIV_DAY: begin
                mul_a = {7'd0, x_reg[31:7]};
                mul_b = esccd_pkg::RECIP_DAY;
            end
            esccd_pkg::DIV_SEC, esccd_pkg::DIV_MIN: begin
                mul_a = {17'd0, x_reg[16:2]};
                mul_b = esccd_pkg::RECIP_MIN;
            end
            default: begin
                mul_a = x_reg;
                mul_b = esccd_pkg::RECIP_MS;
            end
        endcase
    end

    assign prod = {29'd0, mul_a} * {32'd0, mul_b};

    // Drop the fraction bits of the scaled product
    always_comb begin
        unique case (sel_reg)
            esccd_pkg::DIV_MS:                      q_calc = {9'd0, prod[60:38]};
            esccd_pkg::DIV_DAY:                     q_calc = {6'd0, prod[60:35]};
            esccd_pkg::DIV_SEC, esccd_pkg::DIV_MIN: q_calc = {20'd0, prod[30:19]};
            default:                                q_calc = {9'd0, prod[60:38]};
        endcase
    end

    // Remainder from the quotient multiplied back
    assign back   = q_reg * {15'd0, esccd_pkg::div_divisor(sel_reg)};
    assign r_full = x_reg - back;

    always_comb begin
        sel_next  = sel_reg;
        x_next    = x_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        mul_next  = start;
        sub_next  = mul_reg;
        done_next = sub_reg;
        if (start) begin
            sel_next = sel;
            x_next   = dividend;
        end
        if (mul_reg) begin
            q_next = q_calc;
        end
        if (sub_reg) begin
            r_next = r_full[16:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mul_reg  <= 1'b0;
            sub_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            mul_reg  <= mul_next;
            sub_reg  <= sub_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        sel_reg <= sel_next;
        x_reg   <= x_next;
        q_reg   <= q_next;
        r_reg   <= r_next;
    end

    assign done      = done_reg;
    assign quotient  = q_reg;
    assign remainder = r_reg;

endmodule

>>> hdl/esccd_dpath.sv
// Datapath: zone register, working registers, shared divider and calendar walk
module esccd_dpath (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_we,
    input  logic signed [16:0]     cfg_data,
    input  logic [31:0]            in_base_seconds,
    input  logic [31:0]            in_set_at_ms,
    input  logic [31:0]            in_now_ms,
    input  esccd_pkg::ctrl_cmd_t   cmd,
    output esccd_pkg::dp_status_t  status,
    output logic [5:0]             out_second_of_minute,
    output logic [5:0]             out_minute_of_hour,
    output logic [4:0]             out_hour_of_day,
    output logic [4:0]             out_day_of_month,
    output logic [3:0]             out_month_of_year,
    output logic [11:0]            out_calendar_year
);

    logic signed [16:0] zone_reg, zone_next;
    logic [31:0] base_reg, base_next;
    logic [31:0] diff_reg, diff_next;
    logic [31:0] t_reg, t_next;
    logic [15:0] days_reg, days_next;
    logic [16:0] rday_reg, rday_next;
    logic [10:0] mtot_reg, mtot_next;
    logic [5:0]  sec_reg, sec_next;
    logic [5:0]  min_reg, min_next;
    logic [4:0]  hour_reg, hour_next;
    logic [11:0] year_reg, year_next;
    logic [3:0]  month_reg, month_next;

    logic [5:0]  osec_reg, osec_next;
    logic [5:0]  omin_reg, omin_next;
    logic [4:0]  ohour_reg, ohour_next;
    logic [4:0]  oday_reg, oday_next;
    logic [3:0]  omonth_reg, omonth_next;
    logic [11:0] oyear_reg, oyear_next;

    logic [31:0] div_dividend;
    logic        div_done;
    logic [31:0] div_quot;
    logic [16:0] div_rem;
    logic [31:0] zone_ext;
    logic [8:0]  year_len;
    logic [4:0]  month_len;

    // Select the dividend of the next split
    always_comb begin
        unique case (cmd.div_sel)
            esccd_pkg::DIV_MS:  div_dividend = diff_reg;
            esccd_pkg::DIV_DAY: div_dividend = t_reg;
            esccd_pkg::DIV_SEC: div_dividend = {15'd0, rday_reg};
            esccd_pkg::DIV_MIN: div_dividend = {21'd0, mtot_reg};
            default:            div_dividend = diff_reg;
        endcase
    end

    esccd_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (cmd.div_start),
        .sel       (cmd.div_sel),
        .dividend  (div_dividend),
        .done      (div_done),
        .quotient  (div_quot),
        .remainder (div_rem)
    );

    assign zone_ext  = {{15{zone_reg[16]}}, zone_reg};
    assign year_len  = esccd_pkg::days_in_year(year_reg);
    assign month_len = esccd_pkg::days_in_month(month_reg, esccd_pkg::is_leap(year_reg));

    // Report divider completion and the end of the year and month walks
    always_comb begin
        status.div_done   = div_done;
        status.year_done  = (days_reg < {7'd0, year_len});
        status.month_done = (month_reg == esccd_pkg::LAST_MONTH) ||
                            (days_reg < {11'd0, month_len});
    end

    // Next values of the working and output registers
    always_comb begin
        zone_next   = cfg_we ? cfg_data : zone_reg;
        base_next   = base_reg;
        diff_next   = diff_reg;
        t_next      = t_reg;
        days_next   = days_reg;
        rday_next   = rday_reg;
        mtot_next   = mtot_reg;
        sec_next    = sec_reg;
        min_next    = min_reg;
        hour_next   = hour_reg;
        year_next   = year_reg;
        month_next  = month_reg;
        osec_next   = osec_reg;
        omin_next   = omin_reg;
        ohour_next  = ohour_reg;
        oday_next   = oday_reg;
        omonth_next = omonth_reg;
        oyear_next  = oyear_reg;

        // Capture the request and its wrapped tick difference
        if (cmd.load_in) begin
            base_next = in_base_seconds;
            diff_next = in_now_ms - in_set_at_ms;
        end
        // Form local seconds modulo 2^32
        if (cmd.take_elapsed) begin
            t_next = base_reg + div_quot + zone_ext;
        end
        // Split into day count and second of day, start the calendar walk
        if (cmd.take_days) begin
            days_next  = div_quot[15:0];
            rday_next  = div_rem;
            year_next  = esccd_pkg::EPOCH_YEAR;
            month_next = 4'd1;
        end
        if (cmd.take_sec) begin
            sec_next  = div_rem[5:0];
            mtot_next = div_quot[10:0];
        end
        if (cmd.take_min) begin
            min_next  = div_rem[5:0];
            hour_next = div_quot[4:0];
        end
        // Drop one whole year
        if (cmd.year_step) begin
            days_next = days_reg - {7'd0, year_len};
            year_next = year_reg + 12'd1;
        end
        // Drop one whole month
        if (cmd.month_step) begin
            days_next  = days_reg - {11'd0, month_len};
            month_next = month_reg + 4'd1;
        end
        // Load the result register
        if (cmd.load_out) begin
            osec_next   = sec_reg;
            omin_next   = min_reg;
            ohour_next  = hour_reg;
            oday_next   = days_reg[4:0] + 5'd1;
            omonth_next = month_reg;
            oyear_next  = year_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_reg <= esccd_pkg::ZONE_RESET;
        end else begin
            zone_reg <= zone_next;
        end
    end

    always_ff @(posedge aclk) begin
        base_reg   <= base_next;
        diff_reg   <= diff_next;
        t_reg      <= t_next;
        days_reg   <= days_next;
        rday_reg   <= rday_next;
        mtot_reg   <= mtot_next;
        sec_reg    <= sec_next;
        min_reg    <= min_next;
        hour_reg   <= hour_next;
        year_reg   <= year_next;
        month_reg  <= month_next;
        osec_reg   <= osec_next;
        omin_reg   <= omin_next;
        ohour_reg  <= ohour_next;
        oday_reg   <= oday_next;
        omonth_reg <= omonth_next;
        oyear_reg  <= oyear_next;
    end

    assign out_second_of_minute = osec_reg;
    assign out_minute_of_hour   = omin_reg;
    assign out_hour_of_day      = ohour_reg;
    assign out_day_of_month     = oday_reg;
    assign out_month_of_year    = omonth_reg;
    assign out_calendar_year    = oyear_reg;

endmodule

>>> hdl/esccd_ctrl.sv
// Controller: sequences divisions, year and month walks, and the result handshake
module esccd_ctrl (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output esccd_pkg::ctrl_cmd_t   cmd,
    input  esccd_pkg::dp_status_t  status
);

    typedef enum logic [11:0] {
        ST_IDLE     = 12'b0000_0000_0001,
        ST_MS_GO    = 12'b0000_0000_0010,
        ST_MS_WAIT  = 12'b0000_0000_0100,
        ST_DAY_GO   = 12'b0000_0000_1000,
        ST_DAY_WAIT = 12'b0000_0001_0000,
        ST_SEC_GO   = 12'b0000_0010_0000,
        ST_SEC_WAIT = 12'b0000_0100_0000,
        ST_MIN_GO   = 12'b0000_1000_0000,
        ST_MIN_WAIT = 12'b0001_0000_0000,
        ST_YEAR     = 12'b0010_0000_0000,
        ST_MONTH    = 12'b0100_0000_0000,
        ST_OUT      = 12'b1000_0000_0000
    } state_t;

    state_t state_reg, state_next;
    logic   m_tvalid_reg, m_tvalid_next;
    logic   out_free;

    assign out_free = !m_tvalid_reg || m_tready;

    // Advance through the conversion steps
    always_comb begin
        cmd         = '0;
        cmd.div_sel = esccd_pkg::DIV_MS;
        state_next  = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_MS_GO;
                end
            end
            ST_MS_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = esccd_pkg::DIV_MS;
                state_next    = ST_MS_WAIT;
            end
            ST_MS_WAIT: begin
                if (status.div_done) begin
                    cmd.take_elapsed = 1'b1;
                    state_next       = ST_DAY_GO;
                end
            end
            ST_DAY_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = esccd_pkg::DIV_DAY;
                state_next    = ST_DAY_WAIT;
            end
            ST_DAY_WAIT: begin
                if (status.div_done) begin
                    cmd.take_days = 1'b1;
                    state_next    = ST_SEC_GO;
                end
            end
            ST_SEC_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = esccd_pkg::DIV_SEC;
                state_next    = ST_SEC_WAIT;
            end
            ST_SEC_WAIT: begin
                if (status.div_done) begin
                    cmd.take_sec = 1'b1;
                    state_next   = ST_MIN_GO;
                end
            end
            ST_MIN_GO: begin
                cmd.div_start = 1'b1;
                cmd.div_sel   = esccd_pkg::DIV_MIN;
                state_next    = ST_MIN_WAIT;
            end
            ST_MIN_WAIT: begin
                if (status.div_done) begin
                    cmd.take_min = 1'b1;
                    state_next   = ST_YEAR;
                end
            end
            ST_YEAR: begin
                if (status.year_done) begin
                    state_next = ST_MONTH;
                end else begin
                    cmd.year_step = 1'b1;
                end
            end
            ST_MONTH: begin
                if (status.month_done) begin
                    state_next = ST_OUT;
                end else begin
                    cmd.month_step = 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    cmd.load_out = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold the result valid until it is taken
    always_comb begin
        if (cmd.load_out) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end else begin
            m_tvalid_next = m_tvalid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;

endmodule

>>> hdl/esccd_checker.sv
// Port-level checker of the civil date core and its bind
`include "epoch_seconds_to_civil_date_core_macros.svh"

module esccd_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [39:0] m_tdata
);

    // A stalled result stays offered
    `ESCCD_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)

    // An accepted request keeps the block busy in the next cycle
    `ESCCD_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)

    // Time of day fields stay in range
    `ESCCD_ASSERT_SAME(a_time_range, m_tvalid, (m_tdata[5:0] < 6'd60) && (m_tdata[11:6] < 6'd60) && (m_tdata[16:12] < 5'd24))

    // Date fields stay in range
    `ESCCD_ASSERT_SAME(a_date_range, m_tvalid, (m_tdata[21:17] != 5'd0) && (m_tdata[25:22] != 4'd0) && (m_tdata[25:22] <= 4'd12) && (m_tdata[37:26] >= 12'd1970) && (m_tdata[37:26] <= 12'd2106))

endmodule

bind epoch_seconds_to_civil_date_core esccd_checker u_esccd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
